// ===== hdl/csb_pkg.sv =====
// Shared types and constants for the clipped sprite blitter.
// Used by the front end, the queue, the back end and the top level; no dependencies.
package csb_pkg;

    // Default geometry of the screen and the sprite store.
    parameter int SCREEN_COLS_DEF   = 128;
    parameter int SCREEN_ROWS_DEF   = 64;
    parameter int SPRITE_FRAMES_DEF = 4;

    // Sprite geometry: eight rows of one byte, two frame bytes per row.
    localparam int SPRITE_ROWS = 8;
    localparam logic [3:0] STEP_LAST = 4'd15;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_BLIT  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CLIP_NONE  = 2'd0,
        CLIP_FULL  = 2'd1,
        CLIP_LEFT  = 2'd2,
        CLIP_RIGHT = 2'd3
    } clip_t;

    // One classified operation as it travels from the front to the back end.
    typedef struct packed {
        cmd_t        cmd;
        clip_t       kind;      // placement of a blit, CLIP_NONE when nothing is drawn
        logic        mode;      // 0 OR, 1 XOR
        logic [1:0]  frame;
        logic [5:0]  row_y;
        logic [4:0]  col;       // first frame byte column of the sprite
        logic [2:0]  rsh;       // bit offset within that byte
        logic [2:0]  srow;
        logic [7:0]  sdata;
        logic [9:0]  fb_addr;
        logic        ok;        // read address in range, or loaded frame in range
    } csb_op_t;

endpackage

// ===== hdl/clipped_sprite_blitter_core.sv =====
// Top level of the clipped sprite blitter: front end, queue and back end.
// Depends on csb_pkg, csb_front, csb_queue and csb_back.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid/cfg_ready    cfg_data (camera_x)
//   s         in         s_valid/s_ready        cmd, world_x, row_y, x_offset, merge_mode,
//                                               frame_sel, sprite_row, sprite_data, fb_addr
//   m         out        m_valid/m_ready        read_data, clip_case
//
// A drawn blit in the back end runs sixteen byte read-modify-write steps through the
// single read and single write port of the frame store, plus pop and drain.
// A read is the pop and a read state, a load or an undrawn blit only the pop, a clear
// the pop, then one byte of the frame store a cycle.
// After reset the same sweep clears the frame store while s_ready stays low.
// The two-entry queue and the result register let the front accept beats while a
// result waits to be taken.
module clipped_sprite_blitter_core import csb_pkg::*; #(
    parameter int SCREEN_COLS   = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = SCREEN_ROWS_DEF,
    parameter int SPRITE_FRAMES = SPRITE_FRAMES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [15:0]       s_world_x,
    input  logic [5:0]        s_row_y,
    input  logic signed [7:0] s_x_offset,
    input  logic              s_merge_mode,
    input  logic [1:0]        s_frame_sel,
    input  logic [2:0]        s_sprite_row,
    input  logic [7:0]        s_sprite_data,
    input  logic [9:0]        s_fb_addr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_data,
    output logic [1:0]        m_clip_case
);

    logic    init_done;
    logic    qi_valid, qi_ready;
    csb_op_t qi_op;
    logic    qo_valid, qo_ready;
    csb_op_t qo_op;

    csb_front #(
        .SCREEN_COLS   (SCREEN_COLS),
        .SCREEN_ROWS   (SCREEN_ROWS),
        .SPRITE_FRAMES (SPRITE_FRAMES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .init_done     (init_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_world_x     (s_world_x),
        .s_row_y       (s_row_y),
        .s_x_offset    (s_x_offset),
        .s_merge_mode  (s_merge_mode),
        .s_frame_sel   (s_frame_sel),
        .s_sprite_row  (s_sprite_row),
        .s_sprite_data (s_sprite_data),
        .s_fb_addr     (s_fb_addr),
        .q_in_valid    (qi_valid),
        .q_in_ready    (qi_ready),
        .q_in_op       (qi_op)
    );

    csb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qi_valid),
        .in_ready  (qi_ready),
        .in_op     (qi_op),
        .out_valid (qo_valid),
        .out_ready (qo_ready),
        .out_op    (qo_op)
    );

    csb_back #(
        .SCREEN_COLS   (SCREEN_COLS),
        .SCREEN_ROWS   (SCREEN_ROWS),
        .SPRITE_FRAMES (SPRITE_FRAMES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init_done   (init_done),
        .q_valid     (qo_valid),
        .q_ready     (qo_ready),
        .q_op        (qo_op),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_clip_case (m_clip_case)
    );

endmodule

// ===== hdl/csb_front.sv =====
// Front end: camera register, input beat capture, culling and placement of blits.
// Depends on csb_pkg.
module csb_front import csb_pkg::*; #(
    parameter int SCREEN_COLS   = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = SCREEN_ROWS_DEF,
    parameter int SPRITE_FRAMES = SPRITE_FRAMES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init_done,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [15:0]       s_world_x,
    input  logic [5:0]        s_row_y,
    input  logic signed [7:0] s_x_offset,
    input  logic              s_merge_mode,
    input  logic [1:0]        s_frame_sel,
    input  logic [2:0]        s_sprite_row,
    input  logic [7:0]        s_sprite_data,
    input  logic [9:0]        s_fb_addr,
    output logic              q_in_valid,
    input  logic              q_in_ready,
    output csb_op_t           q_in_op
);

    localparam int FB_SIZE = SCREEN_ROWS * (SCREEN_COLS / 8);
    localparam logic signed [17:0] S_FULL_MAX = 18'(SCREEN_COLS - 8);
    localparam logic signed [17:0] S_COLS     = 18'(SCREEN_COLS);
    localparam logic signed [17:0] S_LEFT_MIN = -18'sd8;

    typedef struct packed {
        cmd_t        cmd;
        logic        culled;
        logic [15:0] d16;
        logic [7:0]  off;
        logic        mode;
        logic [1:0]  frame;
        logic [5:0]  row_y;
        logic [2:0]  srow;
        logic [7:0]  sdata;
        logic [9:0]  fb_addr;
        logic        frame_ok;
        logic        addr_ok;
    } stage_t;

    logic [15:0] cam_reg;
    logic [15:0] cam_hi_reg;
    logic        a_valid_reg;
    stage_t      a_reg;
    stage_t      a_next;
    logic [15:0] lo_sum;
    logic        s_accept;
    logic signed [17:0] s_pos;
    clip_t       kind;

    // The user must write the camera register only while the block is idle; the block itself does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg    <= 16'd0;
            cam_hi_reg <= 16'(SCREEN_COLS);
        end else if (cfg_valid) begin
            cam_reg    <= cfg_data;
            cam_hi_reg <= cfg_data + 16'(SCREEN_COLS);
        end
    end

    // Capture stage: culling compares and the wrapped distance to the camera.
    assign lo_sum   = s_world_x + 16'd8;
    assign s_ready  = init_done && (!a_valid_reg || q_in_ready);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        a_next.cmd      = cmd_t'(s_cmd);
        a_next.culled   = (s_world_x > cam_hi_reg) || (lo_sum < cam_reg);
        a_next.d16      = s_world_x - cam_reg;
        a_next.off      = s_x_offset;
        a_next.mode     = s_merge_mode;
        a_next.frame    = s_frame_sel;
        a_next.row_y    = s_row_y;
        a_next.srow     = s_sprite_row;
        a_next.sdata    = s_sprite_data;
        a_next.fb_addr  = s_fb_addr;
        a_next.frame_ok = 5'(s_frame_sel) < 5'(SPRITE_FRAMES);
        a_next.addr_ok  = 14'(s_fb_addr) < 14'(FB_SIZE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (q_in_ready) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_reg <= a_next;
        end
    end

    // Placement stage: screen position and clip class, then push to the queue.
    assign s_pos = $signed({{2{a_reg.d16[15]}}, a_reg.d16})
                 + $signed({{10{a_reg.off[7]}}, a_reg.off});

    always_comb begin
        if (s_pos >= 18'sd0 && s_pos <= S_FULL_MAX) begin
            kind = CLIP_FULL;
        end else if (s_pos < 18'sd0 && s_pos > S_LEFT_MIN) begin
            kind = CLIP_LEFT;
        end else if (s_pos < S_COLS && s_pos > S_FULL_MAX) begin
            kind = CLIP_RIGHT;
        end else begin
            kind = CLIP_NONE;
        end
    end

    assign q_in_valid = a_valid_reg;

    always_comb begin
        q_in_op.cmd     = a_reg.cmd;
        q_in_op.kind    = (a_reg.cmd == CMD_BLIT && !a_reg.culled && a_reg.frame_ok)
                          ? kind : CLIP_NONE;
        q_in_op.mode    = a_reg.mode;
        q_in_op.frame   = a_reg.frame;
        q_in_op.row_y   = a_reg.row_y;
        q_in_op.col     = s_pos[7:3];
        q_in_op.rsh     = s_pos[2:0];
        q_in_op.srow    = a_reg.srow;
        q_in_op.sdata   = a_reg.sdata;
        q_in_op.fb_addr = a_reg.fb_addr;
        q_in_op.ok      = (a_reg.cmd == CMD_READ) ? a_reg.addr_ok : a_reg.frame_ok;
    end

endmodule

// ===== hdl/csb_queue.sv =====
// Two-entry queue of classified operations between the front and the back end.
// Depends on csb_pkg.
module csb_queue import csb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  csb_op_t in_op,
    output logic    out_valid,
    input  logic    out_ready,
    output csb_op_t out_op
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    csb_op_t     slots_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = count_reg != (PW+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// ===== hdl/csb_back.sv =====
// Back end: frame store and sprite store, blit read-modify-write sequencer,
// clearing sweep and the result register. Depends on csb_pkg.
module csb_back import csb_pkg::*; #(
    parameter int SCREEN_COLS   = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = SCREEN_ROWS_DEF,
    parameter int SPRITE_FRAMES = SPRITE_FRAMES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    output logic       init_done,
    input  logic       q_valid,
    output logic       q_ready,
    input  csb_op_t    q_op,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic [1:0] m_clip_case
);

    localparam int ROW_BYTES = SCREEN_COLS / 8;
    localparam int FB_SIZE   = SCREEN_ROWS * ROW_BYTES;
    localparam int FB_AW     = $clog2(FB_SIZE);
    localparam int SPR_DEPTH = SPRITE_FRAMES * SPRITE_ROWS;
    localparam int SPR_AW    = $clog2(SPR_DEPTH);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BLIT,
        ST_DRAIN,
        ST_READ,
        ST_CLEAR
    } state_t;

    state_t        state_reg;
    csb_op_t       op_reg;
    logic [3:0]    cnt_reg;
    logic [FB_AW-1:0] clr_cnt_reg;
    logic          m_valid_reg;
    logic [7:0]    m_read_data_reg;
    logic [1:0]    m_clip_case_reg;
    logic          wr_valid_reg;
    logic [FB_AW-1:0] wr_addr_reg;
    logic          wr_lo_reg;

    logic [7:0]    fb_mem [FB_SIZE];
    logic [7:0]    spr_mem [SPR_DEPTH];
    logic [7:0]    fb_rd_reg;
    logic [7:0]    spr_rd_reg;

    logic          fb_re, fb_we, spr_re, spr_we;
    logic [FB_AW-1:0]  fb_raddr, fb_waddr;
    logic [7:0]        fb_wdata;
    logic [SPR_AW-1:0] spr_raddr, spr_waddr;

    logic          pop;
    logic          clr_last;
    logic          res_set;
    logic [7:0]    res_read_data;
    clip_t         res_clip;

    logic [8:0]    step_row;
    logic [5:0]    step_col;
    logic          step_use;
    logic          step_valid;
    logic [15:0]   step_lin;
    logic [FB_AW-1:0] step_addr;
    logic [15:0]   shifted;
    logic [7:0]    merge_val;
    logic [7:0]    spr_lin_rd;
    logic [7:0]    spr_lin_wr;

    assign init_done   = state_reg != ST_INIT;
    assign q_ready     = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign pop         = q_ready && q_valid;
    assign clr_last    = clr_cnt_reg == FB_AW'(FB_SIZE - 1);
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_clip_case = m_clip_case_reg;

    // Byte step of a blit: even steps hit the first byte, odd steps the second.
    always_comb begin
        step_row = 9'(op_reg.row_y) + 9'(cnt_reg[3:1]);
        if (cnt_reg[0]) begin
            step_col = (op_reg.kind == CLIP_LEFT) ? 6'd0 : 6'(op_reg.col) + 6'd1;
        end else begin
            step_col = 6'(op_reg.col);
        end
        case (op_reg.kind)
            CLIP_FULL:  step_use = 1'b1;
            CLIP_LEFT:  step_use = cnt_reg[0];
            CLIP_RIGHT: step_use = !cnt_reg[0];
            default:    step_use = 1'b0;
        endcase
        step_valid = step_use && (step_row < 9'(SCREEN_ROWS)) && (step_col < 6'(ROW_BYTES));
        step_lin   = 16'(step_row) * 16'(ROW_BYTES) + 16'(step_col);
        step_addr  = FB_AW'(step_lin);
    end

    // Merge value of the sprite byte read in the previous cycle.
    assign shifted   = {spr_rd_reg, 8'h00} >> op_reg.rsh;
    assign merge_val = wr_lo_reg ? shifted[7:0] : shifted[15:8];

    assign spr_lin_rd = {3'b000, op_reg.frame, cnt_reg[3:1]};
    assign spr_lin_wr = {3'b000, q_op.frame, q_op.srow};

    // Memory port control.
    always_comb begin
        fb_re     = 1'b0;
        fb_raddr  = step_addr;
        fb_we     = 1'b0;
        fb_waddr  = wr_addr_reg;
        fb_wdata  = op_reg.mode ? (fb_rd_reg ^ merge_val) : (fb_rd_reg | merge_val);
        spr_re    = 1'b0;
        spr_raddr = SPR_AW'(spr_lin_rd);
        spr_we    = 1'b0;
        spr_waddr = SPR_AW'(spr_lin_wr);
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                fb_we    = 1'b1;
                fb_waddr = clr_cnt_reg;
                fb_wdata = 8'h00;
            end
            ST_IDLE: begin
                fb_re    = pop && q_op.cmd == CMD_READ && q_op.ok;
                fb_raddr = FB_AW'(q_op.fb_addr);
                spr_we   = pop && q_op.cmd == CMD_LOAD && q_op.ok;
            end
            ST_BLIT: begin
                fb_re  = step_valid;
                spr_re = 1'b1;
                fb_we  = wr_valid_reg;
            end
            ST_DRAIN: begin
                fb_we = wr_valid_reg;
            end
            default: begin
            end
        endcase
    end

    // Result of the operation that finishes in this cycle.
    always_comb begin
        res_set       = 1'b0;
        res_read_data = 8'h00;
        res_clip      = CLIP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    case (q_op.cmd)
                        CMD_BLIT:  res_set = q_op.kind == CLIP_NONE;
                        CMD_READ:  res_set = !q_op.ok;
                        CMD_LOAD:  res_set = 1'b1;
                        default:   res_set = 1'b0;
                    endcase
                end
            end
            ST_READ: begin
                res_set       = 1'b1;
                res_read_data = fb_rd_reg;
            end
            ST_DRAIN: begin
                res_set  = 1'b1;
                res_clip = op_reg.kind;
            end
            ST_CLEAR: begin
                res_set = clr_last;
            end
            default: begin
            end
        endcase
    end

    // Frame store: one read and one write port, registered read data.
    always_ff @(posedge aclk) begin
        if (fb_we) begin
            fb_mem[fb_waddr] <= fb_wdata;
        end
        if (fb_re) begin
            fb_rd_reg <= fb_mem[fb_raddr];
        end
    end

    // Sprite store.
    always_ff @(posedge aclk) begin
        if (spr_we) begin
            spr_mem[spr_waddr] <= q_op.sdata;
        end
        if (spr_re) begin
            spr_rd_reg <= spr_mem[spr_raddr];
        end
    end

    // Sequencer state and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cnt_reg      <= 4'd0;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= (state_reg == ST_BLIT) && step_valid;
            wr_addr_reg  <= step_addr;
            wr_lo_reg    <= cnt_reg[0];

            if (res_set) begin
                m_valid_reg     <= 1'b1;
                m_read_data_reg <= res_read_data;
                m_clip_case_reg <= res_clip;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    if (clr_last) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (pop) begin
                        op_reg  <= q_op;
                        cnt_reg <= 4'd0;
                        case (q_op.cmd)
                            CMD_BLIT: begin
                                if (q_op.kind != CLIP_NONE) begin
                                    state_reg <= ST_BLIT;
                                end
                            end
                            CMD_READ: begin
                                if (q_op.ok) begin
                                    state_reg <= ST_READ;
                                end
                            end
                            CMD_CLEAR: state_reg <= ST_CLEAR;
                            default: begin
                            end
                        endcase
                    end
                end
                ST_BLIT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == STEP_LAST) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: state_reg <= ST_IDLE;
                ST_READ:  state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // A read never hits the byte that is written in the same cycle.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (fb_re && fb_we) |-> (fb_raddr != fb_waddr))
        else $error("frame store read and write collide");

    // A new result is only produced when the result register is free.
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_set |-> (!m_valid_reg || m_ready))
        else $error("result overwrites an untaken beat");

    // The frame store is written only by a sweep or a blit.
    a_fb_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        fb_we |-> (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_BLIT
                   || state_reg == ST_DRAIN))
        else $error("frame store written outside a sweep or blit");

    // No operation leaves the queue while the reset sweep runs.
    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !q_ready)
        else $error("queue popped during the reset sweep");

endmodule
